### hw/rtl/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types and constants for the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_ORDER_DEF  = 16;
    localparam int KNOT_DEPTH_DEF = 64;
    localparam int ADDR_EXT_W     = 11;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [4:0]  TARGET_RST = 5'd4;

    localparam logic ACT_KNOT = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INDEX    = 2'd1;
    localparam logic [1:0] ERR_ZERO_DEN = 2'd2;
    localparam logic [1:0] ERR_ORDER    = 2'd3;

    typedef struct packed {
        logic               action;
        logic [5:0]         knot_address;
        logic signed [31:0] knot_value;
        logic signed [31:0] position;
        logic [5:0]         interval_index;
        logic               restart;
    } bbe_in_t;

    typedef struct packed {
        logic [30:0] basis_value;
        logic [3:0]  basis_number;
        logic        last;
        logic [1:0]  error;
    } bbe_out_t;

    typedef struct packed {
        logic       knot_wr;
        logic       eval_start;
        logic       rd_right;
        logic       cap_dr;
        logic       cap_dl;
        logic       clr_i;
        logic       inc_i;
        logic       commit;
        logic       mul;
        logic       prep;
        logic       div_step;
        logic       upd;
        logic       fin;
        logic       clr_k;
        logic       emit_load;
        logic       err_load;
        logic [1:0] err_code;
    } bbe_cmd_t;

    typedef struct packed {
        logic [3:0] degree;
        logic       order_err;
        logic       index_err;
        logic       chk_zero;
        logic       i_last;
        logic       div_done;
        logic       k_last;
    } bbe_stat_t;

endpackage

### hw/rtl/bbe_datapath.sv
// ----------------------------------------------------------------------------
// bbe_datapath
// Knot store, basis and difference arrays, multiplier and serial divider.
// ----------------------------------------------------------------------------
module bbe_datapath
    import bbe_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int KNOT_DEPTH = KNOT_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  bbe_in_t   item,
    input  bbe_cmd_t  cmd,
    output bbe_stat_t stat,
    output bbe_out_t  result
);

    localparam int IW          = $clog2(MAX_ORDER);
    localparam int AW          = $clog2(KNOT_DEPTH);
    localparam int ORDER_LIMIT = (MAX_ORDER < 16) ? MAX_ORDER : 16;

    function automatic logic [IW-1:0] to_idx(input logic [3:0] v);
        logic [4:0] t;
        t = {1'b0, v};
        return t[IW-1:0];
    endfunction

    logic [31:0]        knot_mem [KNOT_DEPTH];
    logic [31:0]        knot_rd_reg;
    logic signed [31:0] x_reg;
    logic [5:0]         left_reg;
    logic [3:0]         degree_reg;
    logic [3:0]         i_reg;
    logic [3:0]         k_reg;
    logic signed [32:0] dr_reg;
    logic signed [32:0] dl_reg;
    logic [30:0]        basis_reg [MAX_ORDER];
    logic signed [32:0] ldiff_reg [MAX_ORDER];
    logic signed [32:0] rdiff_reg [MAX_ORDER];
    logic [30:0]        saved_reg;
    logic signed [64:0] prod_reg;
    logic signed [33:0] d_reg;
    logic [30:0]        b_reg;
    logic [65:0]        rem_reg;
    logic [34:0]        den_reg;
    logic [30:0]        quo_reg;
    logic [4:0]         bit_reg;
    logic               zero_reg;
    logic               sat_reg;
    bbe_out_t           out_reg;

    logic [ADDR_EXT_W-1:0] sum_r;
    logic [ADDR_EXT_W-1:0] sum_l;
    logic [ADDR_EXT_W-1:0] rd_addr;
    logic [ADDR_EXT_W-1:0] wr_addr;
    logic [IW-1:0]         i_idx;
    logic [IW-1:0]         jmi_idx;
    logic [IW-1:0]         j_idx;
    logic [IW-1:0]         j1_idx;
    logic [IW-1:0]         k_idx;
    logic signed [32:0]    r_c;
    logic signed [32:0]    l_c;
    logic [33:0]           d_c;
    logic signed [32:0]    r_m;
    logic signed [32:0]    l_m;
    logic signed [64:0]    prod_next;
    logic [63:0]           mp;
    logic [33:0]           md;
    logic [65:0]           num;
    logic [65:0]           trial;
    logic [30:0]           share;

    always_comb
    begin
        sum_r   = {5'b0, left_reg} + {7'b0, degree_reg};
        sum_l   = {5'b0, left_reg} - {7'b0, degree_reg} - ADDR_EXT_W'(1);
        rd_addr = cmd.rd_right ? sum_r : sum_l;
        wr_addr = {5'b0, item.knot_address};
        i_idx   = to_idx(i_reg);
        jmi_idx = to_idx(degree_reg - i_reg);
        j_idx   = to_idx(degree_reg);
        j1_idx  = to_idx(degree_reg + 4'd1);
        k_idx   = to_idx(k_reg);

        r_c = (i_reg == degree_reg) ? dr_reg : rdiff_reg[i_idx];
        l_c = (i_reg == 4'd0) ? dl_reg : ldiff_reg[jmi_idx];
        d_c = {r_c[32], r_c} + {l_c[32], l_c};

        r_m       = rdiff_reg[i_idx];
        l_m       = ldiff_reg[jmi_idx];
        prod_next = r_m * $signed({1'b0, basis_reg[i_idx]});

        mp  = prod_reg[64] ? 64'(-prod_reg) : prod_reg[63:0];
        md  = d_reg[33] ? 34'(-d_reg) : d_reg;
        num = {1'b0, mp, 1'b0} + {32'b0, md};

        trial = {31'b0, den_reg} << bit_reg;

        if (zero_reg)
            share = '0;
        else if (sat_reg || (quo_reg > b_reg))
            share = b_reg;
        else
            share = quo_reg;
    end

    always_comb
    begin
        stat.degree    = degree_reg;
        stat.order_err = ({1'b0, degree_reg} + 5'd1) >= 5'(ORDER_LIMIT);
        stat.index_err = (sum_r >= ADDR_EXT_W'(KNOT_DEPTH))
                       || ({1'b0, left_reg} < ({3'b0, degree_reg} + 7'd1));
        stat.chk_zero  = (d_c == 34'd0);
        stat.i_last    = (i_reg == degree_reg);
        stat.div_done  = (bit_reg == 5'd0);
        stat.k_last    = (k_reg == degree_reg);
    end

    assign result = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.knot_wr && (wr_addr < ADDR_EXT_W'(KNOT_DEPTH)))
            knot_mem[wr_addr[AW-1:0]] <= item.knot_value;
        knot_rd_reg <= knot_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            x_reg    <= item.position;
            left_reg <= item.interval_index;
        end
        if (cmd.cap_dr)
            dr_reg <= $signed({knot_rd_reg[31], knot_rd_reg}) - $signed({x_reg[31], x_reg});
        if (cmd.cap_dl)
            dl_reg <= $signed({x_reg[31], x_reg}) - $signed({knot_rd_reg[31], knot_rd_reg});
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            d_reg    <= {r_m[32], r_m} + {l_m[32], l_m};
            b_reg    <= basis_reg[i_idx];
        end
        if (cmd.prep)
        begin
            zero_reg <= (prod_reg == 65'sd0) || (prod_reg[64] != d_reg[33]);
            sat_reg  <= num >= {md, 1'b0, 31'b0};
            rem_reg  <= num;
            den_reg  <= {md, 1'b0};
            quo_reg  <= '0;
            bit_reg  <= 5'd30;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                quo_reg <= quo_reg | (31'd1 << bit_reg);
            end
            bit_reg <= bit_reg - 5'd1;
        end
        if (cmd.commit)
            saved_reg <= '0;
        else if (cmd.upd)
            saved_reg <= b_reg - share;
        if (cmd.emit_load)
        begin
            out_reg.basis_value  <= basis_reg[k_idx];
            out_reg.basis_number <= k_reg;
            out_reg.last         <= (k_reg == degree_reg);
            out_reg.error        <= ERR_NONE;
        end
        else if (cmd.err_load)
        begin
            out_reg.basis_value  <= '0;
            out_reg.basis_number <= '0;
            out_reg.last         <= 1'b1;
            out_reg.error        <= cmd.err_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            for (int n = 0; n < MAX_ORDER; n++)
            begin
                basis_reg[n] <= '0;
                ldiff_reg[n] <= '0;
                rdiff_reg[n] <= '0;
            end
        end
        else
        begin
            if (cmd.eval_start && item.restart)
            begin
                degree_reg            <= '0;
                basis_reg[to_idx('0)] <= Q30_ONE;
            end
            if (cmd.clr_i)
                i_reg <= '0;
            else if (cmd.inc_i)
                i_reg <= i_reg + 4'd1;
            if (cmd.commit)
            begin
                rdiff_reg[j_idx] <= dr_reg;
                ldiff_reg[j_idx] <= dl_reg;
            end
            if (cmd.upd)
                basis_reg[i_idx] <= saved_reg + share;
            if (cmd.fin)
            begin
                basis_reg[j1_idx] <= saved_reg;
                degree_reg        <= degree_reg + 4'd1;
            end
            if (cmd.clr_k)
                k_reg <= '0;
            else if (cmd.emit_load)
                k_reg <= k_reg + 4'd1;
        end
    end

endmodule

### hw/rtl/bbe_ctrl.sv
// ----------------------------------------------------------------------------
// bbe_ctrl
// Sequencer for knot loads, order raising, result delivery and the register.
// ----------------------------------------------------------------------------
module bbe_ctrl
    import bbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  bbe_in_t   item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  logic      cfg_we,
    input  logic [4:0] cfg_wdata,
    input  bbe_stat_t stat,
    output bbe_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_START = 12'b000000000010,
        S_RD_R  = 12'b000000000100,
        S_RD_L  = 12'b000000001000,
        S_CHK   = 12'b000000010000,
        S_COMM  = 12'b000000100000,
        S_MUL   = 12'b000001000000,
        S_PREP  = 12'b000010000000,
        S_DIV   = 12'b000100000000,
        S_UPD   = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] target_reg;
    logic       raise_reg, raise_next;
    logic       valid_reg, valid_next;
    logic       err_reg, err_next;
    logic [1:0] code_reg, code_next;
    logic [4:0] tgt_eff;
    logic       out_free;
    logic       accept;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = valid_reg;
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !valid_reg || !rsp_stall;
    assign tgt_eff   = (target_reg == 5'd0) ? 5'd1 : target_reg;

    always_comb
    begin
        state_next = state_reg;
        raise_next = raise_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.err_code = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.action == ACT_EVAL)
                    begin
                        cmd.eval_start = 1'b1;
                        raise_next     = !item.restart;
                        state_next     = S_START;
                    end
                    else
                        cmd.knot_wr = 1'b1;
                end
            end
            S_START:
            begin
                cmd.clr_k = 1'b1;
                if (raise_reg || (({1'b0, stat.degree} + 5'd1) < tgt_eff))
                begin
                    if (stat.order_err)
                    begin
                        err_next   = 1'b1;
                        code_next  = ERR_ORDER;
                        state_next = S_OUT;
                    end
                    else if (stat.index_err)
                    begin
                        err_next   = 1'b1;
                        code_next  = ERR_INDEX;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.rd_right = 1'b1;
                        state_next   = S_RD_R;
                    end
                end
                else
                begin
                    err_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_RD_R:
            begin
                cmd.cap_dr = 1'b1;
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                cmd.cap_dl = 1'b1;
                cmd.clr_i  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.chk_zero)
                begin
                    err_next   = 1'b1;
                    code_next  = ERR_ZERO_DEN;
                    state_next = S_OUT;
                end
                else if (stat.i_last)
                    state_next = S_COMM;
                else
                    cmd.inc_i = 1'b1;
            end
            S_COMM:
            begin
                cmd.commit = 1'b1;
                cmd.clr_i  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (stat.i_last)
                    state_next = S_FIN;
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                raise_next = 1'b0;
                state_next = S_START;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (err_reg)
                    begin
                        cmd.err_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_load = 1'b1;
                        if (stat.k_last)
                            state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit_load || cmd.err_load)
            valid_next = 1'b1;
        else if (out_free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            target_reg <= TARGET_RST;
            raise_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            err_reg    <= 1'b0;
            code_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            raise_reg <= raise_next;
            valid_reg <= valid_next;
            err_reg   <= err_next;
            code_reg  <= code_next;
            if (cfg_we)
                target_reg <= cfg_wdata;
        end
    end

endmodule

### hw/rtl/bspline_basis_evaluator_top.sv
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_top
// B-spline basis evaluation by the de Boor recurrence in fixed point.
//
//   channel  handshake            payload
//   cmd      cmd_valid/cmd_stall  cmd_item  (bbe_in_t)
//   rsp      rsp_valid/rsp_stall  rsp_item  (bbe_out_t)
//   cfg      cfg_we               cfg_wdata (target order)
//
// A knot load is written as it is accepted. Each raise from degree j reads
// two knots, checks j+1 denominators and runs j+1 terms through the shared
// multiplier and one-bit-per-cycle divider; results follow one per cycle
// while rsp_stall is low. Reset clears the basis and difference arrays and
// the degree at once. A stalled result holds its register; the next item is
// taken once the last result of the set has been loaded.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator_top
    import bbe_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int KNOT_DEPTH = KNOT_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  bbe_in_t    cmd_item,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output bbe_out_t   rsp_item,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata
);

    bbe_cmd_t  cmd;
    bbe_stat_t stat;

    bbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .item      (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd)
    );

    bbe_datapath #(
        .MAX_ORDER  (MAX_ORDER),
        .KNOT_DEPTH (KNOT_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (cmd_item),
        .cmd    (cmd),
        .stat   (stat),
        .result (rsp_item)
    );

endmodule

### tb/bspline_basis_evaluator_checker.sv
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_checker
// Watches the cmd and rsp channels of the B-spline basis evaluator, stores
// knot loads, predicts basis values in fixed point for each evaluation and
// compares each accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator_checker
    import bbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       cmd_stall,
    input  bbe_in_t    cmd_item,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  bbe_out_t   rsp_item,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDER_CAP = (MAX_ORDER_DEF < 16) ? MAX_ORDER_DEF : 16;

    logic signed [31:0] knots [KNOT_DEPTH_DEF];
    logic [30:0]        basis [MAX_ORDER_DEF];
    logic signed [63:0] dleft [MAX_ORDER_DEF];
    logic signed [63:0] dright [MAX_ORDER_DEF];
    int unsigned        degree;
    logic [4:0]         order_goal;
    bbe_out_t           expected_basis [$];

    function automatic logic [30:0] right_share(logic signed [63:0] r, logic [30:0] b,
                                                logic signed [63:0] d);
        logic signed [63:0] p;
        logic [63:0]        mp;
        logic [63:0]        md;
        logic [63:0]        q;
        p = r * $signed({33'd0, b});
        if (p == 0 || ((p < 0) != (d < 0)))
            return '0;
        mp = (p < 0) ? -p : p;
        md = (d < 0) ? -d : d;
        q = (2 * mp + md) / (2 * md);
        if (q > b)
            q = b;
        return q[30:0];
    endfunction

    function automatic logic [1:0] raise_basis(int unsigned lft, logic signed [63:0] x);
        int unsigned        j;
        logic signed [63:0] dr;
        logic signed [63:0] dl;
        logic signed [63:0] r;
        logic signed [63:0] l;
        logic [30:0]        b;
        logic [30:0]        a;
        logic [30:0]        carry;
        j = degree;
        carry = '0;
        if (j + 1 >= ORDER_CAP)
            return ERR_ORDER;
        if (lft + j >= KNOT_DEPTH_DEF || lft < j + 1)
            return ERR_INDEX;
        dr = 64'(knots[lft + j]) - x;
        dl = x - 64'(knots[lft - j - 1]);
        for (int i = 0; i <= j; i++)
        begin
            r = (i == j) ? dr : dright[i];
            l = (i == 0) ? dl : dleft[j - i];
            if (r + l == 0)
                return ERR_ZERO_DEN;
        end
        dright[j] = dr;
        dleft[j] = dl;
        for (int i = 0; i <= j; i++)
        begin
            r = dright[i];
            b = basis[i];
            a = right_share(r, b, r + dleft[j - i]);
            basis[i] = carry + a;
            carry = b - a;
        end
        basis[j + 1] = carry;
        degree = j + 1;
        return ERR_NONE;
    endfunction

    task automatic predict_basis(bbe_in_t it);
        int unsigned        goal;
        logic               must;
        logic [1:0]         err;
        logic signed [63:0] x;
        bbe_out_t           o;
        if (it.action == ACT_KNOT)
        begin
            knots[it.knot_address] = it.knot_value;
            return;
        end
        x = 64'(it.position);
        goal = (order_goal == 0) ? 1 : order_goal;
        must = !it.restart;
        if (it.restart)
        begin
            degree = 0;
            basis[0] = Q30_ONE;
        end
        while (must || degree + 1 < goal)
        begin
            must = 1'b0;
            err = raise_basis(it.interval_index, x);
            if (err != ERR_NONE)
            begin
                o = '{basis_value: '0, basis_number: '0, last: 1'b1, error: err};
                expected_basis.push_back(o);
                return;
            end
        end
        for (int k = 0; k <= degree; k++)
        begin
            o = '{basis_value: basis[k], basis_number: 4'(k), last: (k == degree),
                  error: ERR_NONE};
            expected_basis.push_back(o);
        end
    endtask

    task automatic compare_basis(bbe_out_t got);
        bbe_out_t e;
        if (expected_basis.size() == 0)
        begin
            $error("unexpected result %p", got);
            fail_count++;
            return;
        end
        e = expected_basis.pop_front();
        if (got.basis_value !== e.basis_value)
        begin
            $error("basis_value expected %0d actual %0d", e.basis_value, got.basis_value);
            fail_count++;
        end
        if (got.basis_number !== e.basis_number)
        begin
            $error("basis_number expected %0d actual %0d", e.basis_number, got.basis_number);
            fail_count++;
        end
        if (got.last !== e.last)
        begin
            $error("last expected %0d actual %0d", e.last, got.last);
            fail_count++;
        end
        if (got.error !== e.error)
        begin
            $error("error expected %0d actual %0d", e.error, got.error);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            degree = 0;
            order_goal = TARGET_RST;
            expected_basis.delete();
            for (int i = 0; i < MAX_ORDER_DEF; i++)
            begin
                basis[i] = '0;
                dleft[i] = '0;
                dright[i] = '0;
            end
            for (int i = 0; i < KNOT_DEPTH_DEF; i++)
                knots[i] = '0;
        end
        else
        begin
            if (cfg_we)
                order_goal = cfg_wdata;
            if (rsp_valid && !rsp_stall)
                compare_basis(rsp_item);
            if (cmd_valid && !cmd_stall)
                predict_basis(cmd_item);
        end
        pending_count = expected_basis.size();
    end

endmodule

### tb/bspline_basis_evaluator_top_tb.sv
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_top_tb
// Loads knot sets, sweeps the target order and sends directed and random
// evaluations with random idle cycles on both channels; verdict from the
// checker's failure and pending counts.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator_top_tb
    import bbe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    bbe_in_t    cmd_item;
    logic       rsp_valid;
    logic       rsp_stall;
    bbe_out_t   rsp_item;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    int         fail_count;
    int         pending_count;
    logic       idle_free;

    bspline_basis_evaluator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    bspline_basis_evaluator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        rsp_stall <= !idle_free && ($urandom_range(99) < 14);

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(bbe_in_t it);
        while (!idle_free && $urandom_range(99) < 14)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic load_knot(int addr, logic signed [31:0] v);
        bbe_in_t it;
        it = '0;
        it.action = ACT_KNOT;
        it.knot_address = 6'(addr);
        it.knot_value = v;
        send_item(it);
    endtask

    task automatic evaluate(logic signed [31:0] x, int lft, logic rs);
        bbe_in_t it;
        it = '0;
        it.action = ACT_EVAL;
        it.position = x;
        it.interval_index = 6'(lft);
        it.restart = rs;
        it.knot_address = 6'($urandom);
        it.knot_value = $urandom;
        send_item(it);
    endtask

    task automatic set_order(int ord);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 5'(ord);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Strictly increasing knots spaced by step, all 64 written.
    task automatic load_uniform(int step);
        for (int i = 0; i < 64; i++)
            load_knot(i, 32'(i * step - 32 * step));
    endtask

    initial
    begin
        int lft;
        int step;
        logic signed [31:0] x;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        idle_free = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_uniform(32'h1_0000);
        // continue on the stored zero values
        evaluate(32'sd0, 20, 1'b0);
        evaluate(32'sh0000_8000 - 32'sd12 * 32'sh1_0000, 20, 1'b1);
        evaluate(32'sh0000_4000 - 32'sd12 * 32'sh1_0000, 20, 1'b0);
        evaluate(32'sh7fff_ffff, 20, 1'b1);
        evaluate(32'sh8000_0000, 20, 1'b1);
        evaluate(32'sd0, 0, 1'b1);
        evaluate(32'sd0, 63, 1'b1);
        load_knot(63, 32'sh7fff_ffff);
        load_knot(0, 32'sh8000_0000);
        load_knot(10, 32'h1_0000 * 10 - 32'h20_0000);
        load_knot(11, 32'h1_0000 * 10 - 32'h20_0000);
        evaluate(32'h1_0000 * 10 - 32'h20_0000, 11, 1'b1);
        set_order(0);
        evaluate(32'sd5, 30, 1'b1);
        evaluate(32'sd5, 30, 1'b0);
        set_order(16);
        evaluate(32'sd7, 32, 1'b1);
        evaluate(32'sd7, 32, 1'b0);
        set_order(31);
        evaluate(32'sd7, 32, 1'b1);
        set_order(1);
        for (int n = 0; n < 16; n++)
            evaluate(32'sd9, 32, 1'b0);
        evaluate(32'sd9, 32, 1'b1);

        step = 32'h1_0000;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_order((phase == 0) ? 2 : (phase == 3) ? 16 : $urandom_range(1, 8));
            if (phase == 2)
            begin
                step = $urandom_range(1, 32'h8_0000);
                load_uniform(step);
            end
            idle_free = (phase == 1);
            for (int n = 0; n < 12; n++)
            begin
                if ($urandom_range(99) < 10)
                    load_knot($urandom_range(63), $urandom);
                lft = $urandom_range(99) < 85 ? $urandom_range(8, 56) : $urandom_range(63);
                x = 32'(lft * step - 32 * step - step / 2 + $urandom_range(0, step / 4));
                if ($urandom_range(99) < 8)
                    x = $urandom;
                evaluate(x, lft, $urandom_range(99) < 60);
            end
        end
        idle_free = 1'b0;
        cmd_valid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
